// ===== hdl/nidc_pkg.sv =====
// Shared types, codes and arithmetic helpers for the national ID checksum checker.
`default_nettype none

package nidc_pkg;

    localparam int unsigned IdLen     = 11;
    localparam int unsigned PosSat    = 12;
    localparam int unsigned SumLen    = 10;

    localparam logic [7:0]  AsciiZero = 8'd48;
    localparam logic [7:0]  AsciiNine = 8'd57;
    localparam logic [7:0]  SexBias   = 8'd47;

    localparam logic [11:0] Base19xx  = 12'd1900;
    localparam logic [11:0] Base20xx  = 12'd2000;
    localparam logic [6:0]  MonthOff  = 7'd20;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_LONG  = 3'd2,
        ST_SEX   = 3'd3,
        ST_CHAR  = 3'd4,
        ST_SUM   = 3'd5,
        ST_MONTH = 3'd6,
        ST_DAY   = 3'd7
    } t_status;

    // Per-string state as it stands once the current word has been folded in.
    typedef struct packed {
        logic [3:0] count;
        logic [3:0] sum_mod;
        logic       bad_char;
        logic [7:0] tenth_char;
        logic [6:0] year_digits;
        logic [6:0] month_digits;
        logic [6:0] day_digits;
        logic [7:0] check_digit;
    } t_acc_view;

    typedef struct packed {
        t_status     status;
        logic [11:0] birth_year;
        logic [3:0]  birth_month;
        logic [4:0]  birth_day;
    } t_result;

    // Checksum weight by position: 9,7,3,1 repeating.
    function automatic logic [3:0] weight(input logic [1:0] phase);
        logic [3:0] w;
        unique case (phase)
            2'd0: w = 4'd9;
            2'd1: w = 4'd7;
            2'd2: w = 4'd3;
            2'd3: w = 4'd1;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // Remainder by ten of a value below 128: reciprocal multiply, then subtract.
    function automatic logic [3:0] mod10(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [7:0]  qx10;
        logic [7:0]  rem;
        prod = x * 8'd205;
        q    = prod[14:11];
        qx10 = {q, 3'b000} + {3'b000, q, 1'b0};
        rem  = {1'b0, x} - qx10;
        return rem[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nidc_in_if.sv =====
// Input channel: one ID character per word with a last flag.
`default_nettype none

interface nidc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       is_last;

    modport source (output valid, output char_byte, output is_last, input ready);
    modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/nidc_out_if.sv =====
// Result channel: status code and decoded birth date.
`default_nettype none

interface nidc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] birth_year;
    logic [3:0]  birth_month;
    logic [4:0]  birth_day;

    modport source (output valid, output status, output birth_year, output birth_month,
                    output birth_day, input ready);
    modport sink   (input valid, input status, input birth_year, input birth_month,
                    input birth_day, output ready);
endinterface

`default_nettype wire

// ===== hdl/nidc_accum.sv =====
// Per-string accumulator: position count, checksum residue and captured fields.
`default_nettype none

module nidc_accum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_char_byte,
    input  wire logic               i_is_last,
    output nidc_pkg::t_acc_view     o_view
);
    import nidc_pkg::*;

    t_acc_view  r_acc;
    t_acc_view  n_acc;
    logic       is_digit;
    logic [3:0] dv;
    logic [7:0] dv_off;
    logic [6:0] dv_x10;
    logic [6:0] sum_raw;

    assign is_digit = (i_char_byte >= AsciiZero) && (i_char_byte <= AsciiNine);
    assign dv_off   = i_char_byte - AsciiZero;
    assign dv       = is_digit ? dv_off[3:0] : 4'd0;
    assign dv_x10   = {dv, 3'b000} + {2'b00, dv, 1'b0};
    assign sum_raw  = {3'b000, r_acc.sum_mod} + (dv * weight(r_acc.count[1:0]));

    always_comb begin
        n_acc = r_acc;
        if (r_acc.count < 4'(IdLen)) begin
            if (!is_digit) begin
                n_acc.bad_char = 1'b1;
            end
            if (r_acc.count < 4'(SumLen)) begin
                n_acc.sum_mod = mod10(sum_raw);
            end
            unique case (r_acc.count)
                4'd0:    n_acc.year_digits  = dv_x10;
                4'd1:    n_acc.year_digits  = r_acc.year_digits + {3'b000, dv};
                4'd2:    n_acc.month_digits = dv_x10;
                4'd3:    n_acc.month_digits = r_acc.month_digits + {3'b000, dv};
                4'd4:    n_acc.day_digits   = dv_x10;
                4'd5:    n_acc.day_digits   = r_acc.day_digits + {3'b000, dv};
                4'd9:    n_acc.tenth_char   = i_char_byte;
                4'd10:   n_acc.check_digit  = i_char_byte;
                default: ;
            endcase
        end
        // saturate the count
        if (r_acc.count < 4'(PosSat)) begin
            n_acc.count = r_acc.count + 4'd1;
        end
    end

    assign o_view = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_step) begin
            if (i_is_last) begin
                r_acc <= '0;
            end else begin
                r_acc <= n_acc;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nidc_eval.sv =====
// Final checks on a completed string: length, sex, characters, checksum, date.
`default_nettype none

module nidc_eval (
    input  wire nidc_pkg::t_acc_view i_view,
    input  wire logic                i_expected_sex,
    output nidc_pkg::t_result        o_result
);
    import nidc_pkg::*;

    logic       sex_bad;
    logic       sum_bad;
    logic       month_lo;
    logic       month_hi;
    logic       day_bad;
    logic [7:0] check_off;
    logic [6:0] month_adj;

    // Remainder of (tenth - 47) with truncating division: -1 never matches.
    always_comb begin
        if (i_view.tenth_char >= SexBias) begin
            sex_bad = (!i_view.tenth_char[0]) != i_expected_sex;
        end else if (!i_view.tenth_char[0]) begin
            sex_bad = 1'b1;
        end else begin
            sex_bad = i_expected_sex;
        end
    end

    assign check_off = i_view.check_digit - AsciiZero;
    assign sum_bad   = (check_off != {4'd0, i_view.sum_mod});
    assign month_lo  = (i_view.month_digits >= 7'd1)  && (i_view.month_digits <= 7'd12);
    assign month_hi  = (i_view.month_digits >= 7'd21) && (i_view.month_digits <= 7'd32);
    assign day_bad   = (i_view.day_digits == 7'd0) || (i_view.day_digits > 7'd31);
    assign month_adj = i_view.month_digits - MonthOff;

    always_comb begin
        o_result = '0;
        priority if (i_view.count < 4'(IdLen)) begin
            o_result.status = ST_SHORT;
        end else if (i_view.count > 4'(IdLen)) begin
            o_result.status = ST_LONG;
        end else if (sex_bad) begin
            o_result.status = ST_SEX;
        end else if (i_view.bad_char) begin
            o_result.status = ST_CHAR;
        end else if (sum_bad) begin
            o_result.status = ST_SUM;
        end else if (!month_lo && !month_hi) begin
            o_result.status = ST_MONTH;
        end else if (day_bad) begin
            o_result.status = ST_DAY;
        end else begin
            o_result.status      = ST_OK;
            o_result.birth_year  = (month_hi ? Base20xx : Base19xx)
                                   + {5'd0, i_view.year_digits};
            o_result.birth_month = month_hi ? month_adj[3:0] : i_view.month_digits[3:0];
            o_result.birth_day   = i_view.day_digits[4:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/national_id_checksum_checker_core.sv =====
// National ID checksum checker top level: word pipeline, result register, config register.
// A last word accepted into the input register moves on into the result register, from
//   which the sink can take it.
// Throughput: one word per cycle; a word only waits when a last word sits in the input
//   register and the result register is still held by the sink.
// Reset (synchronous, active low) empties both registers, clears all per-string state
//   and sets the expected sex to 0; no clearing pass is needed.
`default_nettype none

module national_id_checksum_checker_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_wr_en,
    input  wire logic   i_cfg_wr_data,
    nidc_in_if.sink     i_char,
    nidc_out_if.source  o_res
);
    import nidc_pkg::*;

    // Input register: holds the accepted word until the accumulator takes it.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // Result register.
    logic       r_out_valid;
    t_result    r_out;

    logic       r_expected_sex;

    logic       out_free;
    logic       s1_move;
    logic       in_take;
    t_acc_view  acc_view;
    t_result    eval_result;

    // The result register frees up when it is empty or being read this cycle.
    assign out_free = !r_out_valid || o_res.ready;
    // A non-last word never needs the result register, so it always advances.
    assign s1_move  = r_s1_valid && (!r_s1_last || out_free);
    assign i_char.ready = !r_s1_valid || s1_move;
    assign in_take  = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_sex <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_expected_sex <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_char.char_byte;
            r_s1_last <= i_char.is_last;
        end
    end

    nidc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_move),
        .i_char_byte (r_s1_byte),
        .i_is_last   (r_s1_last),
        .o_view      (acc_view)
    );

    nidc_eval u_eval (
        .i_view         (acc_view),
        .i_expected_sex (r_expected_sex),
        .o_result       (eval_result)
    );

    // Load the result register when a last word advances; drop it once read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_last) begin
            r_out <= eval_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.birth_year  = r_out.birth_year;
    assign o_res.birth_month = r_out.birth_month;
    assign o_res.birth_day   = r_out.birth_day;

    // A new result only appears right after a last word advanced.
    a_res_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result appeared without a last word");

    // An ok result carries a plausible date.
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_OK) |->
            (r_out.birth_month != 4'd0 && r_out.birth_month <= 4'd12 &&
             r_out.birth_day != 5'd0 && r_out.birth_year >= Base19xx))
        else $error("ok result with out-of-range date");

    // A failing result carries a zero date.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
            (r_out.birth_year == 12'd0 && r_out.birth_month == 4'd0 &&
             r_out.birth_day == 5'd0))
        else $error("failing result with nonzero date");

endmodule

`default_nettype wire
